### src/pfd_pkg.sv
// Shared types, register codes and fixed-point helpers for the two-channel
// PID controller with filtered derivative and integral anti-windup.
// Used by pfd_chan and pid_filtered_derivative_antiwindup.
`default_nettype none

package pfd_pkg;

	localparam int NUM_CHANNELS_DEF = 2;
	localparam int MAX_CHANNELS     = 2;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 64;

	localparam logic [CFG_IDX_W-1:0] REG_P_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_I_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_D_GAIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POLE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SUM_OUT = 3'd6;

	localparam logic signed [48:0] SAT_HI = 49'sd2147483647;
	localparam logic signed [48:0] SAT_LO = -49'sd2147483648;

	typedef struct packed {
		logic signed [31:0] error_zero;
		logic signed [31:0] error_one;
	} pfd_in_t;

	typedef struct packed {
		logic signed [31:0] drive_zero;
		logic signed [31:0] drive_one;
	} pfd_out_t;

	// Pipeline advance strobes shared by the channel datapaths.
	typedef struct packed {
		logic mv1;
		logic mv2;
	} pfd_adv_t;

	function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI) begin
			r = 32'sh7FFFFFFF;
		end else if (v < SAT_LO) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Q16.16 product, floored by the arithmetic shift, then saturated.
	function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
			input logic signed [32:0] b);
		logic signed [64:0] prod;
		logic signed [48:0] q;
		prod = a * b;
		q = prod[64:16];
		return sat32(q);
	endfunction

endpackage

`default_nettype wire

### src/pfd_chan.sv
// One channel of the PID datapath: product stage, integral and derivative
// update stage, and the per-channel state. Depends on pfd_pkg.
`default_nettype none

module pfd_chan (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pfd_pkg::pfd_adv_t  adv,
	input  wire logic signed [31:0] e_s1,
	input  wire logic signed [31:0] kp,
	input  wire logic signed [31:0] ki,
	input  wire logic signed [31:0] kd,
	input  wire logic signed [31:0] pole,
	input  wire logic signed [31:0] upper,
	input  wire logic signed [31:0] lower,
	output logic signed [31:0]      p_s3,
	output logic signed [31:0]      i_s3,
	output logic signed [31:0]      d_s3
);
	import pfd_pkg::*;

	logic signed [31:0] pe_q;
	logic signed [31:0] i_q;
	logic signed [31:0] d_q;

	logic signed [32:0] sum_e;
	logic signed [32:0] diff_e;
	logic signed [31:0] p_nx, mi_nx, md_nx;
	logic signed [31:0] p_s2, mi_s2, md_s2;

	logic signed [31:0] md_pole;
	logic signed [31:0] d_nx;
	logic signed [31:0] i_raw;
	logic signed [32:0] hi, lo;
	logic signed [31:0] i_nx;

	// pe_q already holds the error of the previous request when this one moves.
	always_comb begin
		sum_e  = 33'(e_s1) + 33'(pe_q);
		diff_e = 33'(e_s1) - 33'(pe_q);
		p_nx   = mulq(kp, 33'(e_s1));
		mi_nx  = mulq(ki, sum_e);
		md_nx  = mulq(kd, diff_e);
	end

	always_ff @(posedge clk) begin
		if (adv.mv1) begin
			p_s2  <= p_nx;
			mi_s2 <= mi_nx;
			md_s2 <= md_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pe_q <= '0;
		end else if (adv.mv1) begin
			pe_q <= e_s1;
		end
	end

	always_comb begin
		md_pole = mulq(pole, 33'(d_q));
		d_nx    = sat32(49'(md_s2) + 49'(md_pole));
		i_raw   = sat32(49'(i_q) + 49'(mi_s2));
		hi      = (upper > p_s2) ? (33'(upper) - 33'(p_s2)) : '0;
		lo      = (lower < p_s2) ? (33'(lower) - 33'(p_s2)) : '0;
		// The upper bound is tested first; hi is never negative and lo never positive.
		if (33'(i_raw) > hi) begin
			i_nx = hi[31:0];
		end else if (33'(i_raw) < lo) begin
			i_nx = lo[31:0];
		end else begin
			i_nx = i_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			d_q <= '0;
		end else if (adv.mv2) begin
			i_q <= i_nx;
			d_q <= d_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.mv2) begin
			p_s3 <= p_s2;
			i_s3 <= i_nx;
			d_s3 <= d_nx;
		end
	end

endmodule

`default_nettype wire

### src/pid_filtered_derivative_antiwindup.sv
// Two-channel Q16.16 PID controller with Tustin-filtered derivative and
// integral anti-windup. Top level: configuration, pipeline control, output sum.
// A request moves through e_s1, the s2 and s3 registers and the output register before drive_valid shows it.
// Throughput: one request per cycle; stages hold in place only under output stall.
// Reset clears all configuration registers, channel state and stage valid bits.
// Depends on pfd_pkg and pfd_chan.
`default_nettype none

module pid_filtered_derivative_antiwindup #(
	parameter int NUM_CHANNELS = pfd_pkg::NUM_CHANNELS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [pfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pfd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             error_valid,
	output logic                                  error_stall,
	input  wire pfd_pkg::pfd_in_t                 error,
	output logic                                  drive_valid,
	input  wire logic                             drive_stall,
	output pfd_pkg::pfd_out_t                     drive
);
	import pfd_pkg::*;

	logic [63:0] p_gain_q, i_gain_q, d_gain_q, upper_q, lower_q;
	logic signed [31:0] pole_q;
	logic sum_q;

	logic v1_s1, v2_s2, v3_s3, out_v_q;
	logic free1, free2, free3, free_o;
	pfd_adv_t adv;

	logic signed [31:0] err_in [NUM_CHANNELS];
	logic signed [31:0] e_s1   [NUM_CHANNELS];
	logic signed [31:0] p_s3   [NUM_CHANNELS];
	logic signed [31:0] i_s3   [NUM_CHANNELS];
	logic signed [31:0] d_s3   [NUM_CHANNELS];

	logic signed [35:0] chan_sum [MAX_CHANNELS];
	logic signed [35:0] total;
	pfd_out_t drive_nx;
	pfd_out_t drive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_gain_q <= '0;
			i_gain_q <= '0;
			d_gain_q <= '0;
			pole_q   <= '0;
			upper_q  <= '0;
			lower_q  <= '0;
			sum_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_P_GAIN:  p_gain_q <= cfg_data;
				REG_I_GAIN:  i_gain_q <= cfg_data;
				REG_D_GAIN:  d_gain_q <= cfg_data;
				REG_POLE:    pole_q   <= cfg_data[31:0];
				REG_UPPER:   upper_q  <= cfg_data;
				REG_LOWER:   lower_q  <= cfg_data;
				REG_SUM_OUT: sum_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A stage may load when it is empty or its content moves on this cycle.
	always_comb begin
		free_o      = !out_v_q || !drive_stall;
		free3       = !v3_s3 || free_o;
		free2       = !v2_s2 || free3;
		free1       = !v1_s1 || free2;
		adv.mv1     = v1_s1 && free2;
		adv.mv2     = v2_s2 && free3;
		error_stall = !free1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1   <= 1'b0;
			v2_s2   <= 1'b0;
			v3_s3   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (free1) v1_s1 <= error_valid;
			if (free2) v2_s2 <= v1_s1;
			if (free3) v3_s3 <= v2_s2;
			if (free_o) out_v_q <= v3_s3;
		end
	end

	for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
		if (c == 0) begin : g_zero
			assign err_in[c] = error.error_zero;
		end else begin : g_one
			assign err_in[c] = error.error_one;
		end

		always_ff @(posedge clk) begin
			if (error_valid && free1) begin
				e_s1[c] <= err_in[c];
			end
		end

		pfd_chan u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.e_s1   (e_s1[c]),
			.kp     (p_gain_q[32*c +: 32]),
			.ki     (i_gain_q[32*c +: 32]),
			.kd     (d_gain_q[32*c +: 32]),
			.pole   (pole_q),
			.upper  (upper_q[32*c +: 32]),
			.lower  (lower_q[32*c +: 32]),
			.p_s3   (p_s3[c]),
			.i_s3   (i_s3[c]),
			.d_s3   (d_s3[c])
		);
	end

	always_comb begin
		for (int c = 0; c < MAX_CHANNELS; c++) begin
			chan_sum[c] = '0;
		end
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			chan_sum[c] = 36'(p_s3[c]) + 36'(i_s3[c]) + 36'(d_s3[c]);
		end
		total = chan_sum[0] + chan_sum[1];
		if (sum_q) begin
			drive_nx.drive_zero = sat32(49'(total));
			drive_nx.drive_one  = '0;
		end else begin
			drive_nx.drive_zero = sat32(49'(chan_sum[0]));
			drive_nx.drive_one  = sat32(49'(chan_sum[1]));
		end
	end

	always_ff @(posedge clk) begin
		if (v3_s3 && free_o) begin
			drive_q <= drive_nx;
		end
	end

	assign drive_valid = out_v_q;
	assign drive       = drive_q;

endmodule

`default_nettype wire

### tb/pid_filtered_derivative_antiwindup_tb.sv
// Self-checking testbench for the two-channel Q16.16 PID controller.
// Drives error requests through valid/stall, predicts each drive in the bench
// and compares it with the block's output. Depends on pfd_pkg and the RTL.
`timescale 1ns / 1ps

module pid_filtered_derivative_antiwindup_tb;

	import pfd_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 6;
	localparam int CONFIG_EVERY  = 60;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam logic [31:0] Q_MAX_W = 32'h7FFFFFFF;
	localparam logic [31:0] Q_MIN_W = 32'h80000000;
	localparam logic [31:0] Q_ONE   = 32'h00010000;

	localparam logic signed [65:0] Q_TOP = 66'sd2147483647;
	localparam logic signed [65:0] Q_BOT = -66'sd2147483648;

	logic                  clk;
	logic                  arst_n      = 1'b0;
	logic                  cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  error_valid = 1'b0;
	logic                  error_stall;
	pfd_in_t               error_item  = '0;
	logic                  drive_valid;
	logic                  drive_stall = 1'b0;
	pfd_out_t              drive_item;

	// Bench copy of the configuration registers.
	logic [63:0]        p_gains    = '0;
	logic [63:0]        i_gains    = '0;
	logic [63:0]        d_gains    = '0;
	logic signed [31:0] pole_coef  = '0;
	logic [63:0]        upper_lims = '0;
	logic [63:0]        lower_lims = '0;
	logic               sum_mode   = 1'b0;

	// Bench copy of the per-channel controller state.
	logic signed [31:0] integ_sum [2] = '{default: '0};
	logic signed [31:0] deriv_sum [2] = '{default: '0};
	logic signed [31:0] prev_err  [2] = '{default: '0};

	pfd_out_t pending_drives [$];

	logic [31:0] last_err0 = '0;
	logic [31:0] last_err1 = '0;

	int send_idle_pct   = 0;
	int stall_pct       = 0;
	int hold_left       = 0;
	int fail_count      = 0;
	int items_sent      = 0;
	int results_checked = 0;
	int configs_loaded  = 0;
	int cycle_count     = 0;

	pid_filtered_derivative_antiwindup i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.error_valid(error_valid),
		.error_stall(error_stall),
		.error      (error_item),
		.drive_valid(drive_valid),
		.drive_stall(drive_stall),
		.drive      (drive_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("pid_filtered_derivative_antiwindup verification failed");
			$finish;
		end
	end

	// Output side: random stall, or a forced hold-off while hold_left runs down.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			drive_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			drive_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin : check_drive
		pfd_out_t want;
		if (arst_n && drive_valid && !drive_stall) begin
			results_checked++;
			if (pending_drives.size() == 0) begin
				$display("%0t: drive with no request outstanding, actual %0d %0d",
					$time, drive_item.drive_zero, drive_item.drive_one);
				fail_count++;
			end else begin
				want = pending_drives.pop_front();
				if (drive_item.drive_zero !== want.drive_zero) begin
					$display("%0t: drive_zero mismatch, expected %0d, actual %0d",
						$time, want.drive_zero, drive_item.drive_zero);
					fail_count++;
				end
				if (drive_item.drive_one !== want.drive_one) begin
					$display("%0t: drive_one mismatch, expected %0d, actual %0d",
						$time, want.drive_one, drive_item.drive_one);
					fail_count++;
				end
			end
		end
	end

	function automatic logic signed [31:0] clip32(input logic signed [65:0] v);
		if (v > Q_TOP) begin
			return Q_MAX_W;
		end else if (v < Q_BOT) begin
			return Q_MIN_W;
		end
		return v[31:0];
	endfunction

	// Q16.16 product floored toward minus infinity, then saturated.
	function automatic logic signed [31:0] fix_mul(input logic signed [31:0] a,
			input logic signed [32:0] b);
		logic signed [65:0] prod;
		prod = a * b;
		return clip32(prod >>> 16);
	endfunction

	function automatic pfd_out_t compute_drive(input pfd_in_t item);
		logic signed [31:0] err, kp, ki, kd, up, lo;
		logic signed [32:0] err_sum, err_diff;
		logic signed [65:0] p_term, i_term, d_term, hi_bound, lo_bound, acc, total;
		pfd_out_t res;
		logic signed [65:0] drv [2];
		total = '0;
		for (int c = 0; c < 2; c++) begin
			err = (c == 0) ? item.error_zero : item.error_one;
			kp = p_gains[32*c +: 32];
			ki = i_gains[32*c +: 32];
			kd = d_gains[32*c +: 32];
			up = upper_lims[32*c +: 32];
			lo = lower_lims[32*c +: 32];
			err_sum = err + prev_err[c];
			err_diff = err - prev_err[c];
			p_term = fix_mul(kp, err);
			acc = integ_sum[c];
			acc = acc + fix_mul(ki, err_sum);
			i_term = clip32(acc);
			acc = fix_mul(kd, err_diff);
			acc = acc + fix_mul(pole_coef, deriv_sum[c]);
			d_term = clip32(acc);
			// Bounds are zero when the limit does not clear the proportional term.
			if (up > p_term) begin
				hi_bound = up - p_term;
			end else begin
				hi_bound = '0;
			end
			if (lo < p_term) begin
				lo_bound = lo - p_term;
			end else begin
				lo_bound = '0;
			end
			if (i_term > hi_bound) begin
				i_term = hi_bound;
			end else if (i_term < lo_bound) begin
				i_term = lo_bound;
			end
			integ_sum[c] = i_term[31:0];
			deriv_sum[c] = d_term[31:0];
			prev_err[c] = err;
			drv[c] = p_term + i_term + d_term;
			total = total + drv[c];
		end
		if (sum_mode) begin
			res.drive_zero = clip32(total);
			res.drive_one = '0;
		end else begin
			res.drive_zero = clip32(drv[0]);
			res.drive_one = clip32(drv[1]);
		end
		return res;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_P_GAIN:  p_gains = data;
			REG_I_GAIN:  i_gains = data;
			REG_D_GAIN:  d_gains = data;
			REG_POLE:    pole_coef = data[31:0];
			REG_UPPER:   upper_lims = data;
			REG_LOWER:   lower_lims = data;
			REG_SUM_OUT: sum_mode = data[0];
			default: ;
		endcase
	endtask

	task automatic program_regs(input logic [63:0] pg, input logic [63:0] ig,
			input logic [63:0] dg, input logic [63:0] pl, input logic [63:0] up,
			input logic [63:0] lo, input logic [63:0] sm);
		write_reg(REG_P_GAIN, pg);
		write_reg(REG_I_GAIN, ig);
		write_reg(REG_D_GAIN, dg);
		write_reg(REG_POLE, pl);
		write_reg(REG_UPPER, up);
		write_reg(REG_LOWER, lo);
		write_reg(REG_SUM_OUT, sm);
		configs_loaded++;
	endtask

	task automatic send_request(input pfd_in_t item);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			error_valid <= 1'b0;
			@(posedge clk);
		end
		error_valid <= 1'b1;
		error_item <= item;
		@(posedge clk);
		while (error_stall) @(posedge clk);
		pending_drives.push_back(compute_drive(item));
		items_sent++;
	endtask

	task automatic send_pair(input logic [31:0] e0, input logic [31:0] e1);
		pfd_in_t item;
		item.error_zero = e0;
		item.error_one = e1;
		send_request(item);
	endtask

	// Registers change only once the block has emptied and settled.
	task automatic drain_requests();
		error_valid <= 1'b0;
		@(posedge clk);
		while (pending_drives.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] extreme_word();
		case ($urandom_range(0, 3))
			0: return Q_MAX_W;
			1: return Q_MIN_W;
			2: return '0;
			default: return 32'hFFFFFFFF;
		endcase
	endfunction

	function automatic logic [31:0] rand_gain();
		int v;
		v = $urandom_range(0, 524288);
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return extreme_word();
			default: return v - 262144;
		endcase
	endfunction

	function automatic logic [31:0] rand_limit(input bit upper);
		int v;
		v = $urandom_range(0, 8388608);
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return upper ? Q_MAX_W : Q_MIN_W;
			default: return upper ? v : -v;
		endcase
	endfunction

	function automatic logic [31:0] next_error(input logic [31:0] last);
		int v;
		v = $urandom_range(0, 32768);
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return extreme_word();
			2: return $urandom_range(0, 2097152) - 1048576;
			default: return last + v - 16384;
		endcase
	endfunction

	task automatic program_random_regs();
		logic [63:0] pg, ig, dg, up, lo;
		logic [31:0] pl;
		int pick;
		pick = $urandom_range(0, 5);
		if (pick == 0) begin
			pg = {extreme_word(), extreme_word()};
			ig = {extreme_word(), extreme_word()};
			dg = {extreme_word(), extreme_word()};
			pl = extreme_word();
		end else begin
			pg = {rand_gain(), rand_gain()};
			ig = {rand_gain(), rand_gain()};
			dg = {rand_gain(), rand_gain()};
			pl = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 131072) - 65536;
		end
		up = {rand_limit(1'b1), rand_limit(1'b1)};
		lo = {rand_limit(1'b0), rand_limit(1'b0)};
		// Upper data bits of the narrow registers carry noise that must be ignored.
		program_regs(pg, ig, dg, {$urandom, pl}, up, lo, {$urandom, $urandom});
	endtask

	task automatic test_reset_defaults();
		send_pair(Q_MAX_W, Q_MIN_W);
		send_pair(Q_ONE, -Q_ONE);
		send_pair('0, 32'h12345678);
		drain_requests();
	endtask

	task automatic test_directed_extremes();
		program_regs({32'hFFFE0000, Q_ONE}, {32'h00004000, 32'h00008000},
			{32'h00018000, 32'h0000C000}, 64'h00008000,
			{32'h00320000, 32'h00640000}, {32'hFFCE0000, 32'hFF9C0000}, '0);
		send_pair('0, '0);
		send_pair(Q_MAX_W, Q_MIN_W);
		send_pair(Q_MIN_W, Q_MAX_W);
		send_pair(Q_MAX_W, Q_MAX_W);
		send_pair(Q_MIN_W, Q_MIN_W);
		send_pair(Q_ONE, -Q_ONE);
		send_pair(32'hFFFFFFFF, 32'h00000001);
		send_pair('0, '0);
		drain_requests();
		// Full-scale gains drive the products and sums into saturation.
		program_regs({Q_MAX_W, Q_MIN_W}, {Q_MIN_W, Q_MAX_W}, {Q_MAX_W, Q_MAX_W},
			{32'hFFFFFFFF, Q_MAX_W}, {Q_MAX_W, Q_MAX_W}, {Q_MIN_W, Q_MIN_W}, '0);
		send_pair(Q_MAX_W, Q_MIN_W);
		send_pair(Q_MIN_W, Q_MAX_W);
		send_pair(Q_MAX_W, Q_MAX_W);
		send_pair('0, '0);
		drain_requests();
	endtask

	// Upper limit below lower limit: the upper bound is tested first.
	task automatic test_crossed_limits();
		program_regs({Q_ONE, Q_ONE}, {Q_ONE, Q_ONE}, '0, '0,
			{32'hFFFD0000, Q_ONE}, {32'h00030000, 32'h00040000}, '0);
		send_pair(32'h00020000, 32'hFFFE0000);
		send_pair(32'hFFF00000, 32'h00100000);
		send_pair(32'h00080000, 32'h00080000);
		send_pair('0, '0);
		drain_requests();
	endtask

	task automatic test_sum_mode();
		program_regs({Q_ONE, 32'h00020000}, {32'h00001000, 32'h00002000},
			{32'h00008000, 32'h00004000}, 64'hFFFF8000,
			{Q_MAX_W, Q_MAX_W}, {Q_MIN_W, Q_MIN_W}, 64'd1);
		write_reg(REG_UNUSED, {$urandom, $urandom});
		send_pair(Q_ONE, Q_ONE);
		send_pair(Q_MAX_W, Q_MAX_W);
		send_pair(Q_MIN_W, Q_MIN_W);
		send_pair(Q_MAX_W, Q_MIN_W);
		send_pair('0, '0);
		drain_requests();
	endtask

	// Output held off long enough that the block fills and stalls its input.
	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		program_random_regs();
		hold_left = 150;
		for (int k = 0; k < 40; k++) begin
			last_err0 = next_error(last_err0);
			last_err1 = next_error(last_err1);
			send_pair(last_err0, last_err1);
		end
		drain_requests();
	endtask

	task automatic run_random_phase(input int n_items, input int tx_pct, input int rx_pct);
		send_idle_pct = tx_pct;
		stall_pct = rx_pct;
		for (int k = 0; k < n_items; k++) begin
			if (k % CONFIG_EVERY == 0) begin
				drain_requests();
				program_random_regs();
			end
			last_err0 = next_error(last_err0);
			last_err1 = next_error(last_err1);
			send_pair(last_err0, last_err1);
		end
		drain_requests();
	endtask

	initial begin : run_tests
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed_extremes();
		test_crossed_limits();
		test_sum_mode();
		test_backpressure();
		run_random_phase(360, 14, 88);
		run_random_phase(360, 88, 14);
		run_random_phase(360, 0, 0);
		$display("Checked %0d drives for %0d requests across %0d register settings.",
			results_checked, items_sent, configs_loaded);
		$display("Covered extremes, saturation, crossed limits, sum mode and output hold-off.");
		if (fail_count == 0) begin
			$display("pid_filtered_derivative_antiwindup verification clean");
		end else begin
			$display("pid_filtered_derivative_antiwindup verification failed");
		end
		$finish;
	end

endmodule
